/* hdl/fes_pkg.sv */
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants for the format escape scanner.
// ----------------------------------------------------------------------------
package fes_pkg;

  localparam int MAX_ARG_INDEX_DEF = 255;

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_ESC  = 3'd1;
  localparam logic [2:0] MODE_PCT  = 3'd2;
  localparam logic [2:0] MODE_HEX  = 3'd3;
  localparam logic [2:0] MODE_OCT  = 3'd4;

  localparam logic KIND_LIT  = 1'b0;
  localparam logic KIND_CONV = 1'b1;

  localparam logic [2:0] SPEC_S  = 3'd0;
  localparam logic [2:0] SPEC_D  = 3'd1;
  localparam logic [2:0] SPEC_I  = 3'd2;
  localparam logic [2:0] SPEC_U  = 3'd3;
  localparam logic [2:0] SPEC_X  = 3'd4;
  localparam logic [2:0] SPEC_UX = 3'd5;
  localparam logic [2:0] SPEC_O  = 3'd6;
  localparam logic [2:0] SPEC_C  = 3'd7;

  localparam logic REG_ARG_COUNT = 1'b0;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] dcnt;
    logic [8:0] dval;
    logic [7:0] narg;
  } scan_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_out;
    logic [2:0] spec;
    logic [7:0] arg_number;
    logic       arg_present;
    logic       end_of_string;
    logic       last_of_run;
  } res_t;

  function automatic res_t mk_lit(input logic [7:0] b);
    res_t r;
    r = '0;
    r.kind = KIND_LIT;
    r.byte_out = b;
    return r;
  endfunction

endpackage

/* hdl/fes_decode.sv */
// ----------------------------------------------------------------------------
// fes_decode
// Next-state and result decode for one format string character.
// ----------------------------------------------------------------------------
module fes_decode #(
  parameter int MAX_ARG_INDEX = fes_pkg::MAX_ARG_INDEX_DEF
) (
  input  logic [7:0]     char_in,
  input  logic           is_last,
  input  logic [7:0]     arg_count,
  input  fes_pkg::scan_t cur,
  output fes_pkg::scan_t nxt,
  output logic [1:0]     res_n,
  output fes_pkg::res_t  res0,
  output fes_pkg::res_t  res1
);

  localparam logic [7:0] ARG_LIMIT = (MAX_ARG_INDEX < 255) ? 8'(MAX_ARG_INDEX) : 8'd255;

  fes_pkg::res_t res_v [2];
  logic [1:0]    n_v;
  logic          idle_v;
  logic          hex_ok;
  logic [3:0]    hex_d;
  logic          oct_ok;
  logic [2:0]    oct_d;
  logic          spec_ok;
  logic [2:0]    spec_v;
  logic          present;
  logic [8:0]    nval;
  logic [1:0]    ncnt;
  fes_pkg::scan_t s;

  always_comb begin
    hex_ok = 1'b1;
    hex_d  = 4'd0;
    if (char_in >= "0" && char_in <= "9") begin
      hex_d = 4'(char_in - "0");
    end else if (char_in >= "a" && char_in <= "f") begin
      hex_d = 4'(char_in - "a" + 8'd10);
    end else if (char_in >= "A" && char_in <= "F") begin
      hex_d = 4'(char_in - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
    oct_ok = (char_in >= "0") && (char_in <= "7");
    oct_d  = char_in[2:0];
  end

  always_comb begin
    spec_ok = 1'b1;
    case (char_in)
      "s":     spec_v = fes_pkg::SPEC_S;
      "d":     spec_v = fes_pkg::SPEC_D;
      "i":     spec_v = fes_pkg::SPEC_I;
      "u":     spec_v = fes_pkg::SPEC_U;
      "x":     spec_v = fes_pkg::SPEC_X;
      "X":     spec_v = fes_pkg::SPEC_UX;
      "o":     spec_v = fes_pkg::SPEC_O;
      "c":     spec_v = fes_pkg::SPEC_C;
      default: begin
        spec_v  = fes_pkg::SPEC_S;
        spec_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    s        = cur;
    n_v      = 2'd0;
    res_v[0] = '0;
    res_v[1] = '0;
    idle_v   = 1'b0;
    present  = 1'b0;
    nval     = '0;
    ncnt     = '0;

    case (cur.mode)
      fes_pkg::MODE_ESC: begin
        s.mode = fes_pkg::MODE_IDLE;
        case (char_in)
          "n": begin res_v[0] = fes_pkg::mk_lit(8'd10); n_v = 2'd1; end
          "t": begin res_v[0] = fes_pkg::mk_lit(8'd9);  n_v = 2'd1; end
          "r": begin res_v[0] = fes_pkg::mk_lit(8'd13); n_v = 2'd1; end
          "a": begin res_v[0] = fes_pkg::mk_lit(8'd7);  n_v = 2'd1; end
          "b": begin res_v[0] = fes_pkg::mk_lit(8'd8);  n_v = 2'd1; end
          "f": begin res_v[0] = fes_pkg::mk_lit(8'd12); n_v = 2'd1; end
          "v": begin res_v[0] = fes_pkg::mk_lit(8'd11); n_v = 2'd1; end
          "x": begin
            if (is_last) begin
              res_v[0] = fes_pkg::mk_lit(8'd0);
              n_v = 2'd1;
            end else begin
              s.mode = fes_pkg::MODE_HEX;
              s.dcnt = 2'd0;
              s.dval = '0;
            end
          end
          default: begin
            if (oct_ok) begin
              if (is_last) begin
                res_v[0] = fes_pkg::mk_lit({5'd0, oct_d});
                n_v = 2'd1;
              end else begin
                s.mode = fes_pkg::MODE_OCT;
                s.dcnt = 2'd1;
                s.dval = {6'd0, oct_d};
              end
            end else begin
              res_v[0] = fes_pkg::mk_lit(char_in);
              n_v = 2'd1;
            end
          end
        endcase
      end
      fes_pkg::MODE_PCT: begin
        s.mode = fes_pkg::MODE_IDLE;
        if (char_in == "%") begin
          res_v[0] = fes_pkg::mk_lit("%");
          n_v = 2'd1;
        end else begin
          present = cur.narg < arg_count;
          if (present && cur.narg < ARG_LIMIT) s.narg = cur.narg + 8'd1;
          if (spec_ok) begin
            res_v[0] = '0;
            res_v[0].kind        = fes_pkg::KIND_CONV;
            res_v[0].spec        = spec_v;
            res_v[0].arg_number  = cur.narg;
            res_v[0].arg_present = present;
            n_v = 2'd1;
          end else begin
            res_v[0] = fes_pkg::mk_lit("%");
            res_v[1] = fes_pkg::mk_lit(char_in);
            n_v = 2'd2;
          end
        end
      end
      fes_pkg::MODE_HEX: begin
        if (hex_ok) begin
          nval   = {1'b0, cur.dval[3:0], hex_d};
          ncnt   = cur.dcnt + 2'd1;
          s.dval = nval;
          s.dcnt = ncnt;
          if (ncnt >= 2'd2 || is_last) begin
            res_v[0] = fes_pkg::mk_lit(nval[7:0]);
            n_v = 2'd1;
            s.mode = fes_pkg::MODE_IDLE;
          end
        end else begin
          res_v[0] = fes_pkg::mk_lit(cur.dval[7:0]);
          n_v = 2'd1;
          idle_v = 1'b1;
        end
      end
      fes_pkg::MODE_OCT: begin
        if (oct_ok) begin
          nval   = {cur.dval[5:0], oct_d};
          ncnt   = cur.dcnt + 2'd1;
          s.dval = nval;
          s.dcnt = ncnt;
          if (ncnt == 2'd3 || is_last) begin
            res_v[0] = fes_pkg::mk_lit(nval[7:0]);
            n_v = 2'd1;
            s.mode = fes_pkg::MODE_IDLE;
          end
        end else begin
          res_v[0] = fes_pkg::mk_lit(cur.dval[7:0]);
          n_v = 2'd1;
          idle_v = 1'b1;
        end
      end
      default: idle_v = 1'b1;
    endcase

    if (idle_v) begin
      s.mode = fes_pkg::MODE_IDLE;
      if (char_in == "\\") begin
        if (is_last) begin
          res_v[n_v[0]] = fes_pkg::mk_lit(8'd0);
          n_v = n_v + 2'd1;
        end else begin
          s.mode = fes_pkg::MODE_ESC;
        end
      end else if (char_in == "%") begin
        if (is_last) begin
          res_v[n_v[0]] = fes_pkg::mk_lit("%");
          n_v = n_v + 2'd1;
        end else begin
          s.mode = fes_pkg::MODE_PCT;
        end
      end else begin
        res_v[n_v[0]] = fes_pkg::mk_lit(char_in);
        n_v = n_v + 2'd1;
      end
    end

    if (is_last) begin
      s.mode = fes_pkg::MODE_IDLE;
      s.narg = '0;
    end
    if (s.mode == fes_pkg::MODE_IDLE || s.mode == fes_pkg::MODE_ESC ||
        s.mode == fes_pkg::MODE_PCT) begin
      s.dcnt = '0;
      s.dval = '0;
    end

    if (n_v == 2'd2) begin
      res_v[1].last_of_run   = 1'b1;
      res_v[1].end_of_string = is_last;
    end else if (n_v == 2'd1) begin
      res_v[0].last_of_run   = 1'b1;
      res_v[0].end_of_string = is_last;
    end
  end

  assign nxt   = s;
  assign res_n = n_v;
  assign res0  = res_v[0];
  assign res1  = res_v[1];

endmodule

/* hdl/format_escape_scanner.sv */
// ----------------------------------------------------------------------------
// format_escape_scanner
// Decodes a printf-style format string into literal bytes and conversions.
// ----------------------------------------------------------------------------
//  channel  | ports                      | moves
//  ---------+----------------------------+--------------------------------
//  in       | in_valid / in_stall        | one character word
//  out      | out_valid / out_stall      | one result word (literal/conv)
//  cfg      | psel penable pwrite paddr  | arg_count register at 0x0
//
// One character per cycle while in_stall is low; a character yielding two results
// emits them as two output words, absorbed by a four-word result queue.
// in_stall rises when fewer than two queue slots are free.
// Synchronous active-low reset clears scan state, queue and arg_count.
// Results stay stable while out_stall is high.
module format_escape_scanner #(
  parameter int MAX_ARG_INDEX = fes_pkg::MAX_ARG_INDEX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_in,
  input  logic        in_is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_byte_out,
  output logic [2:0]  out_spec,
  output logic [7:0]  out_arg_number,
  output logic        out_arg_present,
  output logic        out_end_of_string,
  output logic        out_last_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fes_pkg::scan_t scan_r, scan_nxt;
  fes_pkg::res_t  res0, res1;
  fes_pkg::res_t  q_r [4];
  fes_pkg::res_t  head;
  logic [1:0]     res_n;
  logic [1:0]     wr_ptr_r, rd_ptr_r;
  logic [2:0]     cnt_r, cnt_nxt;
  logic [7:0]     arg_count_r;
  logic           push, pop;

  fes_decode #(
    .MAX_ARG_INDEX (MAX_ARG_INDEX)
  ) u_decode (
    .char_in   (in_char_in),
    .is_last   (in_is_last),
    .arg_count (arg_count_r),
    .cur       (scan_r),
    .nxt       (scan_nxt),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  assign in_stall  = cnt_r > 3'd2;
  assign push      = in_valid && !in_stall;
  assign out_valid = cnt_r != 3'd0;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push) cnt_nxt = cnt_nxt + {1'b0, res_n};
    if (pop)  cnt_nxt = cnt_nxt - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        scan_r   <= scan_nxt;
        wr_ptr_r <= wr_ptr_r + res_n;
      end
      if (pop) rd_ptr_r <= rd_ptr_r + 2'd1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && res_n != 2'd0) q_r[wr_ptr_r] <= res0;
    if (push && res_n == 2'd2) q_r[wr_ptr_r + 2'd1] <= res1;
  end

  assign head              = q_r[rd_ptr_r];
  assign out_kind          = head.kind;
  assign out_byte_out      = head.byte_out;
  assign out_spec          = head.spec;
  assign out_arg_number    = head.arg_number;
  assign out_arg_present   = head.arg_present;
  assign out_end_of_string = head.end_of_string;
  assign out_last_of_run   = head.last_of_run;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arg_count_r <= '0;
    end else if (psel && penable && pwrite && paddr[2] == fes_pkg::REG_ARG_COUNT) begin
      arg_count_r <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == fes_pkg::REG_ARG_COUNT) ? {24'd0, arg_count_r} : 32'd0;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for format_escape_scanner. Format strings go in one
// word per character; a built-in scanner model predicts every result word,
// and each accepted result is compared field by field in order. Runs mix
// directed corner strings, token-built random strings at several arg_count
// settings, random gaps and stalls on both sides, and a long output hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [7:0] CH_BSL = 8'h5c;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam int ARG_LIMIT = (fes_pkg::MAX_ARG_INDEX_DEF < 255) ?
                             fes_pkg::MAX_ARG_INDEX_DEF : 255;
  localparam int LONG_HOLD = 200;
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_char_in;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic        out_kind;
  logic [7:0]  out_byte_out;
  logic [2:0]  out_spec;
  logic [7:0]  out_arg_number;
  logic        out_arg_present;
  logic        out_end_of_string;
  logic        out_last_of_run;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  format_escape_scanner dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_char_in(in_char_in), .in_is_last(in_is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_kind(out_kind), .out_byte_out(out_byte_out), .out_spec(out_spec),
    .out_arg_number(out_arg_number), .out_arg_present(out_arg_present),
    .out_end_of_string(out_end_of_string), .out_last_of_run(out_last_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // scanner model state
  logic [7:0]    arg_cnt;
  logic [2:0]    sc_mode;
  logic [1:0]    sc_dcnt;
  logic [8:0]    sc_dval;
  logic [7:0]    sc_narg;
  fes_pkg::res_t char_results[$];
  fes_pkg::res_t pending_results[$];

  int         err_cnt = 0;
  int         sent_cnt = 0;
  int         gap_pct = 20;
  int         stall_pct = 20;
  bit         hold_req = 1'b0;
  logic [7:0] str_buf[$];
  string      named_esc = "ntrabfv\\";
  string      hex_chars = "0123456789abcdefABCDEF";
  string      spec_chars = "sdiuxXoc";

  task automatic report(string what, logic [31:0] got_v, logic [31:0] want_v);
    err_cnt++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got_v, want_v);
  endtask

  function automatic void put_lit(logic [7:0] b);
    fes_pkg::res_t r;
    r = '0;
    r.kind = fes_pkg::KIND_LIT;
    r.byte_out = b;
    char_results.push_back(r);
  endfunction

  function automatic bit spec_lookup(logic [7:0] c, output logic [2:0] sp);
    sp = fes_pkg::SPEC_S;
    case (c)
      "s": sp = fes_pkg::SPEC_S;
      "d": sp = fes_pkg::SPEC_D;
      "i": sp = fes_pkg::SPEC_I;
      "u": sp = fes_pkg::SPEC_U;
      "x": sp = fes_pkg::SPEC_X;
      "X": sp = fes_pkg::SPEC_UX;
      "o": sp = fes_pkg::SPEC_O;
      "c": sp = fes_pkg::SPEC_C;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // conversion or unknown specifier; both consume an argument slot
  function automatic void use_arg(logic [7:0] c);
    fes_pkg::res_t r;
    logic [2:0] sp;
    bit known;
    bit present;
    known = spec_lookup(c, sp);
    present = sc_narg < arg_cnt;
    if (known) begin
      r = '0;
      r.kind = fes_pkg::KIND_CONV;
      r.spec = sp;
      r.arg_number = sc_narg;
      r.arg_present = present;
      char_results.push_back(r);
    end else begin
      put_lit(CH_PCT);
      put_lit(c);
    end
    if (present && sc_narg < ARG_LIMIT) sc_narg = sc_narg + 8'd1;
  endfunction

  function automatic void idle_char(logic [7:0] c, bit fin);
    sc_mode = fes_pkg::MODE_IDLE;
    if (c == CH_BSL) begin
      if (fin) put_lit(8'h00);
      else sc_mode = fes_pkg::MODE_ESC;
    end else if (c == CH_PCT) begin
      if (fin) put_lit(CH_PCT);
      else sc_mode = fes_pkg::MODE_PCT;
    end else begin
      put_lit(c);
    end
  endfunction

  function automatic void escape_char(logic [7:0] c, bit fin);
    sc_mode = fes_pkg::MODE_IDLE;
    case (c)
      "n": put_lit(8'd10);
      "t": put_lit(8'd9);
      "r": put_lit(8'd13);
      "a": put_lit(8'd7);
      "b": put_lit(8'd8);
      "f": put_lit(8'd12);
      "v": put_lit(8'd11);
      "x": begin
        if (fin) begin
          put_lit(8'h00);
        end else begin
          sc_mode = fes_pkg::MODE_HEX;
          sc_dcnt = 2'd0;
          sc_dval = 9'd0;
        end
      end
      default: begin
        if (c >= "0" && c <= "7") begin
          if (fin) begin
            put_lit({5'd0, c[2:0]});
          end else begin
            sc_mode = fes_pkg::MODE_OCT;
            sc_dcnt = 2'd1;
            sc_dval = {6'd0, c[2:0]};
          end
        end else begin
          put_lit(c);
        end
      end
    endcase
  endfunction

  // predicts the result words for one character and queues them
  function automatic void scan_char(logic [7:0] c, bit fin);
    int d;
    int n;
    char_results.delete();
    case (sc_mode)
      fes_pkg::MODE_ESC: escape_char(c, fin);
      fes_pkg::MODE_PCT: begin
        sc_mode = fes_pkg::MODE_IDLE;
        if (c == CH_PCT) put_lit(CH_PCT);
        else use_arg(c);
      end
      fes_pkg::MODE_HEX: begin
        d = hex_digit(c);
        if (d >= 0) begin
          sc_dval = {1'b0, sc_dval[3:0], d[3:0]};
          sc_dcnt = sc_dcnt + 2'd1;
          if (sc_dcnt >= 2'd2 || fin) begin
            put_lit(sc_dval[7:0]);
            sc_mode = fes_pkg::MODE_IDLE;
          end
        end else begin
          put_lit(sc_dval[7:0]);
          idle_char(c, fin);
        end
      end
      fes_pkg::MODE_OCT: begin
        if (c >= "0" && c <= "7") begin
          sc_dval = {sc_dval[5:0], c[2:0]};
          sc_dcnt = sc_dcnt + 2'd1;
          if (sc_dcnt >= 2'd3 || fin) begin
            put_lit(sc_dval[7:0]);
            sc_mode = fes_pkg::MODE_IDLE;
          end
        end else begin
          put_lit(sc_dval[7:0]);
          idle_char(c, fin);
        end
      end
      default: idle_char(c, fin);
    endcase
    if (fin) begin
      sc_mode = fes_pkg::MODE_IDLE;
      sc_narg = 8'd0;
    end
    if (sc_mode == fes_pkg::MODE_IDLE || sc_mode == fes_pkg::MODE_ESC ||
        sc_mode == fes_pkg::MODE_PCT) begin
      sc_dcnt = 2'd0;
      sc_dval = 9'd0;
    end
    n = char_results.size();
    if (n > 0) begin
      char_results[n - 1].last_of_run = 1'b1;
      if (fin) char_results[n - 1].end_of_string = 1'b1;
    end
    foreach (char_results[i]) pending_results.push_back(char_results[i]);
  endfunction

  always @(posedge clk) begin : result_check
    fes_pkg::res_t got;
    fes_pkg::res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) scan_char(in_char_in, in_is_last);
      if (out_valid && !out_stall) begin
        got.kind = out_kind;
        got.byte_out = out_byte_out;
        got.spec = out_spec;
        got.arg_number = out_arg_number;
        got.arg_present = out_arg_present;
        got.end_of_string = out_end_of_string;
        got.last_of_run = out_last_of_run;
        if (pending_results.size() == 0) begin
          report("unexpected word", 32'(got), 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind)
            report("kind", 32'(got.kind), 32'(want.kind));
          if (got.byte_out !== want.byte_out)
            report("byte_out", 32'(got.byte_out), 32'(want.byte_out));
          if (got.spec !== want.spec)
            report("spec", 32'(got.spec), 32'(want.spec));
          if (got.arg_number !== want.arg_number)
            report("arg_number", 32'(got.arg_number), 32'(want.arg_number));
          if (got.arg_present !== want.arg_present)
            report("arg_present", 32'(got.arg_present), 32'(want.arg_present));
          if (got.end_of_string !== want.end_of_string)
            report("end_of_string", 32'(got.end_of_string), 32'(want.end_of_string));
          if (got.last_of_run !== want.last_of_run)
            report("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
        end
      end
    end
  end

  function automatic int idle_len();
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  initial begin : recv_side
    int run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
        out_stall = 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        out_stall = 1'b1;
        run = idle_len();
        repeat (run - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_char(logic [7:0] c, bit fin);
    in_valid = 1'b1;
    in_char_in = c;
    in_is_last = fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_cnt++;
    @(negedge clk);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      repeat (idle_len()) @(negedge clk);
    end
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++) send_char(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic send_buf();
    for (int i = 0; i < str_buf.size(); i++) send_char(str_buf[i], i == str_buf.size() - 1);
  endtask

  function automatic void add_token();
    int k;
    int n;
    k = $urandom_range(11);
    case (k)
      0, 1: str_buf.push_back(8'($urandom_range(255)));
      2: begin
        str_buf.push_back(CH_BSL);
        str_buf.push_back(named_esc[$urandom_range(7)]);
      end
      3: begin
        str_buf.push_back(CH_BSL);
        str_buf.push_back("x");
        n = $urandom_range(2);
        repeat (n) str_buf.push_back(hex_chars[$urandom_range(21)]);
      end
      4: begin
        str_buf.push_back(CH_BSL);
        n = $urandom_range(3, 1);
        repeat (n) str_buf.push_back(8'("0" + $urandom_range(7)));
      end
      5: begin
        str_buf.push_back(CH_BSL);
        str_buf.push_back(8'($urandom_range(255)));
      end
      6, 7, 8: begin
        str_buf.push_back(CH_PCT);
        str_buf.push_back(spec_chars[$urandom_range(7)]);
      end
      9: begin
        str_buf.push_back(CH_PCT);
        str_buf.push_back(CH_PCT);
      end
      default: begin
        str_buf.push_back(CH_PCT);
        str_buf.push_back(8'($urandom_range(255)));
      end
    endcase
  endfunction

  function automatic void build_string(int tokens);
    str_buf.delete();
    repeat (tokens) add_token();
  endfunction

  task automatic drain_results(int settle);
    int waited;
    waited = 0;
    in_valid = 1'b0;
    while (pending_results.size() > 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (pending_results.size() > 0) begin
      report("words never delivered", 32'(pending_results.size()), 32'd0);
      pending_results.delete();
    end
    repeat (settle) @(negedge clk);
  endtask

  task automatic set_arg_count(logic [7:0] v);
    drain_results(8);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {fes_pkg::REG_ARG_COUNT, 2'b00};
    pwdata = {24'd0, v};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    arg_cnt = v;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic test_plain_bytes();
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    send_text("Az", 1'b1);
  endtask

  // arg_count still at its reset value of zero for the first strings
  task automatic test_special_cases();
    send_text("%s%%%q%\\\\x4g\\777\\q%", 1'b1);
    send_text("\\x", 1'b1);
    send_text("\\x4", 1'b1);
    send_text("\\12", 1'b1);
    send_text("\\", 1'b1);
    set_arg_count(8'd2);
    send_text("%d%y%u", 1'b1);
  endtask

  task automatic test_arg_saturation();
    set_arg_count(8'd255);
    str_buf.delete();
    repeat (260) begin
      str_buf.push_back(CH_PCT);
      str_buf.push_back(spec_chars[$urandom_range(7)]);
    end
    str_buf.push_back(".");
    send_buf();
  endtask

  task automatic test_random_strings();
    logic [7:0] setting[6];
    int target;
    setting = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(255)), 8'd3, 8'($urandom_range(8))};
    for (int p = 0; p < 6; p++) begin
      set_arg_count(setting[p]);
      gap_pct = (p == 2) ? 0 : 25;
      stall_pct = (p == 2) ? 0 : ((p == 4) ? 60 : 25);
      target = sent_cnt + 150;
      while (sent_cnt < target) begin
        build_string(($urandom_range(7) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1));
        send_buf();
      end
    end
    gap_pct = 20;
    stall_pct = 20;
  endtask

  task automatic test_backpressure();
    drain_results(8);
    gap_pct = 0;
    hold_req = 1'b1;
    repeat (3) begin
      build_string(30);
      send_buf();
    end
    drain_results(8);
    gap_pct = 20;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_char_in = 8'd0;
    in_is_last = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    arg_cnt = 8'd0;
    sc_mode = fes_pkg::MODE_IDLE;
    sc_dcnt = 2'd0;
    sc_dval = 9'd0;
    sc_narg = 8'd0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_plain_bytes();
    test_special_cases();
    test_arg_saturation();
    test_random_strings();
    test_backpressure();
    drain_results(20);
    if (err_cnt == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
hdl/fes_pkg.sv
hdl/fes_decode.sv
hdl/format_escape_scanner.sv
bench/tb_top.sv
